// ===== design/smkt_pkg.sv =====
// Shared types, constants and codes for the keypoint top-k selector.
package smkt_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_MAX_SIDE = 1024;

  localparam int SCORE_W  = 16;
  localparam int COORD_W  = 10;
  localparam int BORDER_W = 10;
  localparam int LIMIT_W  = 12;
  localparam int SIDE_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;

  // Register values after reset.
  localparam logic [SCORE_W-1:0]         RST_THRESHOLD = 16'd983;
  localparam logic [BORDER_W-1:0]        RST_BORDER    = 10'd4;
  localparam logic signed [LIMIT_W-1:0]  RST_KEEP      = 12'sd1024;
  localparam logic [SIDE_W-1:0]          RST_HEIGHT    = 11'd480;
  localparam logic [SIDE_W-1:0]          RST_WIDTH     = 11'd640;
  localparam logic signed [LIMIT_W-1:0]  KEEP_ALL      = -12'sd1;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_READ   = 2'd1,
    ACT_START  = 2'd2
  } action_t;

  // One ranked point: column, row and score.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  // A point travelling down the chain; full means the list was at its limit
  // when the point entered, so whatever reaches the end slot is dropped.
  // Moved marks a point that was pushed out of its slot by a better one; it
  // takes every later slot in turn, so ties keep their order.
  typedef struct packed {
    logic   valid;
    logic   full;
    logic   moved;
    entry_t entry;
  } carry_t;

endpackage

// ===== design/score_map_keypoint_top_k.sv =====
// Top level of the keypoint threshold, border and top-k selector.
//
// Usage: score words arrive on the in_ stream with in_tuser carrying the
// action (sample, read next point, start new frame) and in_tdata the score.
// Samples are taken in raster order; those above the threshold and inside
// the border margin run down a chain of insertion cells, one cell a cycle,
// so the chain stays sorted by score with earlier points ahead on ties.
// A sample word is accepted in every cycle, also while earlier points are
// still moving down the chain. A read or start word waits until the last
// point has settled, which the settle counter reckons from the length of
// the cell chain.
// A read word gives one result word on the out_ stream in the next cycle:
// column, row and score in out_tdata, point_valid in out_tuser and the
// last point flag in out_tlast. A read of a point shifts the chain by one cell,
// so reads complete one a cycle while the receiver keeps out_tready high;
// when it stalls, the result register holds and further reads wait.
// Configuration words are always accepted and are meant for an idle block.
// After reset the registers hold their defaults and the frame is empty;
// no clearing pass is needed, as only slots below the kept count are read.
module score_map_keypoint_top_k #(
  parameter int CAPACITY = smkt_pkg::DEF_CAPACITY,
  parameter int MAX_SIDE = smkt_pkg::DEF_MAX_SIDE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [smkt_pkg::IN_DATA_W-1:0]      in_tdata,   // [15:0] score
  input  logic [1:0]                          in_tuser,   // [1:0] action
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [smkt_pkg::OUT_DATA_W-1:0]     out_tdata,  // [9:0] point_x,
                                                          // [19:10] point_y,
                                                          // [35:20] point_score
  output logic                                out_tuser,  // [0] point_valid
  output logic                                out_tlast,  // last_point
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smkt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smkt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import smkt_pkg::*;

  localparam int LIM_W  = $clog2(CAPACITY + 1);
  localparam int BUSY_W = $clog2(CAPACITY + 2);
  localparam int CLMP_W = $clog2(MAX_SIDE + 1);
  localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CMP_W  = ((POS_W > BORDER_W) ? POS_W : BORDER_W) + 2;
  localparam logic [LIM_W-1:0]  CAP_LIM  = LIM_W'(CAPACITY);
  localparam logic [BUSY_W-1:0] SETTLE   = BUSY_W'(CAPACITY + 1);

  // A side of zero acts as one; larger sides saturate.
  function automatic logic [CLMP_W-1:0] side_clamp(input logic [SIDE_W-1:0] v);
    logic [CLMP_W-1:0] res;
    if (v == '0) begin
      res = CLMP_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      res = CLMP_W'(MAX_SIDE);
    end else begin
      res = CLMP_W'(v);
    end
    return res;
  endfunction

  // Configuration registers.
  logic [SCORE_W-1:0]        thr_r;
  logic [BORDER_W-1:0]       border_r;
  logic signed [LIMIT_W-1:0] keep_r;
  logic [SIDE_W-1:0]         height_r;
  logic [SIDE_W-1:0]         width_r;

  // Frame state.
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic              done_r, done_nxt;
  logic [LIM_W-1:0]  kept_r, kept_nxt;
  logic [LIM_W-1:0]  rp_r, rp_nxt;
  logic [BUSY_W-1:0] busy_r, busy_nxt;

  // Injection into the head of the chain.
  carry_t            inj_r, inj_nxt;
  logic [LIM_W-1:0]  inj_tag_r, inj_tag_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  entry_t                 out_entry_r, out_entry_nxt;
  logic                   out_pv_r, out_pv_nxt;
  logic                   out_last_r, out_last_nxt;

  action_t           act;
  logic              in_acc;
  logic              out_free;
  logic [LIM_W-1:0]  lim;
  logic [LIM_W-1:0]  n_cut;
  logic [CLMP_W-1:0] h_eff, w_eff;
  logic              candidate;
  logic              rd_ok;
  logic              pop;
  entry_t            head;
  carry_t            tail;
  logic [LIM_W-1:0]  tail_tag;

  assign act      = action_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (act)
      ACT_READ:  in_tready = (busy_r == '0) && out_free;
      ACT_START: in_tready = (busy_r == '0);
      default:   in_tready = 1'b1;
    endcase
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_THRESHOLD;
      border_r <= RST_BORDER;
      keep_r   <= RST_KEEP;
      height_r <= RST_HEIGHT;
      width_r  <= RST_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r    <= cfg_data[SCORE_W-1:0];
        REG_BORDER:    border_r <= cfg_data[BORDER_W-1:0];
        REG_KEEP:      keep_r   <= cfg_data[LIMIT_W-1:0];
        REG_HEIGHT:    height_r <= cfg_data[SIDE_W-1:0];
        REG_WIDTH:     width_r  <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limit: keep everything on -1, nothing on other negatives.
  always_comb begin
    priority if (keep_r == KEEP_ALL) begin
      lim = CAP_LIM;
    end else if (keep_r[LIMIT_W-1]) begin
      lim = '0;
    end else if (32'(keep_r[LIMIT_W-2:0]) > CAPACITY) begin
      lim = CAP_LIM;
    end else begin
      lim = LIM_W'(keep_r[LIMIT_W-2:0]);
    end
  end

  assign h_eff = side_clamp(height_r);
  assign w_eff = side_clamp(width_r);
  assign n_cut = (kept_r < lim) ? kept_r : lim;

  assign candidate = (in_tdata[SCORE_W-1:0] > thr_r)
                  && (CMP_W'(row_r) >= CMP_W'(border_r))
                  && (CMP_W'(row_r) + CMP_W'(border_r) < CMP_W'(h_eff))
                  && (CMP_W'(col_r) >= CMP_W'(border_r))
                  && (CMP_W'(col_r) + CMP_W'(border_r) < CMP_W'(w_eff));

  assign rd_ok = done_r && (rp_r < kept_r) && (32'(rp_r) < CAPACITY);
  assign pop   = in_acc && (act == ACT_READ) && rd_ok;

  // Frame, list and injection control.
  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    done_nxt    = done_r;
    kept_nxt    = kept_r;
    rp_nxt      = rp_r;
    busy_nxt    = (busy_r != '0) ? busy_r - BUSY_W'(1) : busy_r;
    inj_nxt     = '0;
    inj_tag_nxt = n_cut;
    inj_nxt.entry.x     = COORD_W'(col_r);
    inj_nxt.entry.y     = COORD_W'(row_r);
    inj_nxt.entry.score = in_tdata[SCORE_W-1:0];
    if (in_acc) begin
      unique case (act)
        ACT_SAMPLE: begin
          if (!done_r) begin
            if (candidate) begin
              // The list is first cut to the limit, then the point enters.
              kept_nxt = (n_cut == lim) ? lim : n_cut + LIM_W'(1);
              if (lim != '0) begin
                inj_nxt.valid = 1'b1;
                inj_nxt.full  = (n_cut == lim);
                busy_nxt      = SETTLE;
              end
            end
            if (CMP_W'(col_r) + CMP_W'(1) >= CMP_W'(w_eff)) begin
              col_nxt = '0;
              if (CMP_W'(row_r) + CMP_W'(1) >= CMP_W'(h_eff)) begin
                done_nxt = 1'b1;
              end else begin
                row_nxt = row_r + POS_W'(1);
              end
            end else begin
              col_nxt = col_r + POS_W'(1);
            end
          end
        end
        ACT_READ: begin
          if (rd_ok) begin
            rp_nxt = rp_r + LIM_W'(1);
          end
        end
        ACT_START: begin
          row_nxt  = '0;
          col_nxt  = '0;
          done_nxt = 1'b0;
          kept_nxt = '0;
          rp_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  // Result register: a read always answers, with zeros when nothing is left.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_entry_nxt = out_entry_r;
    out_pv_nxt    = out_pv_r;
    out_last_nxt  = out_last_r;
    if (in_acc && (act == ACT_READ)) begin
      out_valid_nxt = 1'b1;
      out_entry_nxt = rd_ok ? head : '0;
      out_pv_nxt    = rd_ok;
      out_last_nxt  = rd_ok && (rp_r + LIM_W'(1) == kept_r);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      done_r      <= 1'b0;
      kept_r      <= '0;
      rp_r        <= '0;
      busy_r      <= '0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      done_r      <= done_nxt;
      kept_r      <= kept_nxt;
      rp_r        <= rp_nxt;
      busy_r      <= busy_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inj_tag_r   <= inj_tag_nxt;
    out_entry_r <= out_entry_nxt;
    out_pv_r    <= out_pv_nxt;
    out_last_r  <= out_last_nxt;
  end

  smkt_chain #(
    .CAPACITY (CAPACITY),
    .TAG_W    (LIM_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .cin      (inj_r),
    .cin_tag  (inj_tag_r),
    .head     (head),
    .tail     (tail),
    .tail_tag (tail_tag)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - SCORE_W - 2 * COORD_W){1'b0}},
                       out_entry_r.score, out_entry_r.y, out_entry_r.x};
  assign out_tuser  = out_pv_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The chain never shifts while a point is still moving through it.
  a_pop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!inj_r.valid && !tail.valid))
    else $error("chain shifted with a point in flight");

  // Only points of a full list of CAPACITY entries fall off the end.
  a_tail_drop: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (tail.full && (tail_tag == CAP_LIM)))
    else $error("point lost off the end of the chain");

  // An injected point always holds the settle counter above zero.
  a_inj_busy: assert property (@(posedge clk) disable iff (!rst_n)
    inj_r.valid |-> (busy_r != '0))
    else $error("point injected without settle time");

  // Every accepted read produces a result word in the next cycle.
  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (act == ACT_READ)) |=> out_valid_r)
    else $error("read gave no result word");
`endif

endmodule

// ===== design/smkt_cell.sv =====
// One slot of the sorted insertion chain.
module smkt_cell #(
  parameter int IDX   = 0,
  parameter int TAG_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop,
  input  smkt_pkg::carry_t  cin,
  input  logic [TAG_W-1:0]  cin_tag,
  input  smkt_pkg::entry_t  right_data,
  output smkt_pkg::carry_t  cout,
  output logic [TAG_W-1:0]  cout_tag,
  output smkt_pkg::entry_t  data
);
  import smkt_pkg::*;

  localparam logic [TAG_W-1:0] MY_IDX = TAG_W'(IDX);

  entry_t            data_r, data_nxt;
  carry_t            cout_r, cout_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;

  always_comb begin
    data_nxt       = data_r;
    cout_nxt       = '0;
    cout_nxt.entry = cin.entry;
    tag_nxt        = cin_tag;
    if (pop) begin
      data_nxt = right_data;
    end else if (cin.valid) begin
      if (cin_tag == MY_IDX) begin
        // The point has reached the free slot at the end of the list.
        if (!cin.full) begin
          data_nxt = cin.entry;
        end
      end else if (cin_tag > MY_IDX) begin
        cout_nxt.valid = 1'b1;
        cout_nxt.full  = cin.full;
        cout_nxt.moved = cin.moved;
        // A new point only takes a slot whose score it strictly beats; a
        // displaced point shifts every later entry along by one.
        if (cin.moved || (cin.entry.score > data_r.score)) begin
          data_nxt       = cin.entry;
          cout_nxt.entry = data_r;
          cout_nxt.moved = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_r <= '0;
    end else begin
      cout_r <= cout_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tag_r  <= tag_nxt;
  end

  assign cout     = cout_r;
  assign cout_tag = tag_r;
  assign data     = data_r;

endmodule

// ===== design/smkt_chain.sv =====
// Row of insertion cells that keeps the list sorted and shifts out on reads.
module smkt_chain #(
  parameter int CAPACITY = smkt_pkg::DEF_CAPACITY,
  parameter int TAG_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop,
  input  smkt_pkg::carry_t  cin,
  input  logic [TAG_W-1:0]  cin_tag,
  output smkt_pkg::entry_t  head,
  output smkt_pkg::carry_t  tail,
  output logic [TAG_W-1:0]  tail_tag
);
  import smkt_pkg::*;

  carry_t            carry [0:CAPACITY];
  logic [TAG_W-1:0]  tag   [0:CAPACITY];
  entry_t            data  [0:CAPACITY];

  assign carry[0] = cin;
  assign tag[0]   = cin_tag;
  // The end slot refills from itself on a shift; it lies past the list then.
  assign data[CAPACITY] = data[CAPACITY-1];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smkt_cell #(
      .IDX   (i),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .pop        (pop),
      .cin        (carry[i]),
      .cin_tag    (tag[i]),
      .right_data (data[i+1]),
      .cout       (carry[i+1]),
      .cout_tag   (tag[i+1]),
      .data       (data[i])
    );
  end

  assign head     = data[0];
  assign tail     = carry[CAPACITY];
  assign tail_tag = tag[CAPACITY];

endmodule
